@@ rtl/rne_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, constants and symbol tables for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

	localparam int VALUE_W   = 10;
	localparam int SYMBOL_W  = 8;
	localparam int POS_W     = 4;
	localparam int DIGIT_W   = 4;
	localparam int REM_W     = 7;
	localparam int LEN_W     = 3;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;
	localparam int FIFO_DEPTH = 4;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd1000;

	localparam logic [SYMBOL_W-1:0] SYM_I = 8'h49;
	localparam logic [SYMBOL_W-1:0] SYM_V = 8'h56;
	localparam logic [SYMBOL_W-1:0] SYM_X = 8'h58;
	localparam logic [SYMBOL_W-1:0] SYM_L = 8'h4C;
	localparam logic [SYMBOL_W-1:0] SYM_C = 8'h43;
	localparam logic [SYMBOL_W-1:0] SYM_D = 8'h44;
	localparam logic [SYMBOL_W-1:0] SYM_M = 8'h4D;
	localparam logic [SYMBOL_W-1:0] SYM_ERR = 8'h00;

	typedef enum logic [1:0] {
		SCALE_HUNDREDS,
		SCALE_TENS,
		SCALE_UNITS
	} scale_t;

	typedef enum logic [1:0] {
		SEL_ONE,
		SEL_FIVE,
		SEL_TEN
	} sel_t;

	// one classified number between the front and the back
	typedef struct packed {
		logic               err;
		logic               thou;
		logic [DIGIT_W-1:0] hund;
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] units;
		logic [POS_W-1:0]   total;
	} desc_t;

	// number of symbols one decimal digit takes
	function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
		logic [LEN_W-1:0] n;
		unique case (d)
			4'd1, 4'd5:        n = 3'd1;
			4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
			4'd3, 4'd7:        n = 3'd3;
			4'd8:              n = 3'd4;
			default:           n = 3'd0;
		endcase
		return n;
	endfunction

	// which of one, five, ten sits at index k of a digit
	function automatic sel_t digit_sel(input logic [DIGIT_W-1:0] d, input logic [1:0] k);
		sel_t s;
		priority if (d == 4'd4) begin
			s = (k == 2'd0) ? SEL_ONE : SEL_FIVE;
		end else if (d == 4'd9) begin
			s = (k == 2'd0) ? SEL_ONE : SEL_TEN;
		end else if (d >= 4'd5) begin
			s = (k == 2'd0) ? SEL_FIVE : SEL_ONE;
		end else begin
			s = SEL_ONE;
		end
		return s;
	endfunction

	function automatic logic [SYMBOL_W-1:0] symbol_of(input scale_t sc, input sel_t s);
		logic [SYMBOL_W-1:0] c;
		unique case (sc)
			SCALE_HUNDREDS: c = (s == SEL_ONE) ? SYM_C : ((s == SEL_FIVE) ? SYM_D : SYM_M);
			SCALE_TENS:     c = (s == SEL_ONE) ? SYM_X : ((s == SEL_FIVE) ? SYM_L : SYM_C);
			SCALE_UNITS:    c = (s == SEL_ONE) ? SYM_I : ((s == SEL_FIVE) ? SYM_V : SYM_X);
			default:        c = SYM_ERR;
		endcase
		return c;
	endfunction

	function automatic logic [VALUE_W-1:0] hundreds_of(input logic [DIGIT_W-1:0] h);
		return VALUE_W'(h) * VALUE_W'(100);
	endfunction

	function automatic logic [REM_W-1:0] tens_of(input logic [DIGIT_W-1:0] t);
		return REM_W'(t) * REM_W'(10);
	endfunction

endpackage

@@ rtl/rne_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_front
// Two-stage classifier: range check, decimal digits and numeral length.
// ----------------------------------------------------------------------------
module rne_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rne_pkg::VALUE_W-1:0] in_value,
	output logic                        push,
	input  logic                        full,
	output rne_pkg::desc_t              push_desc
);
	import rne_pkg::*;

	logic               v_s1;
	logic               err_s1;
	logic               thou_s1;
	logic [DIGIT_W-1:0] hund_s1;
	logic [REM_W-1:0]   rem_s1;
	logic               v_s2;
	desc_t              desc_s2;

	logic               adv1;
	logic               adv2;
	logic [DIGIT_W-1:0] hund_c;
	logic [VALUE_W-1:0] rem_c;
	logic [DIGIT_W-1:0] tens_c;
	logic [REM_W-1:0]   units_c;
	logic [POS_W-1:0]   total_c;

	assign push     = v_s2 && !full;
	assign adv2     = !v_s2 || push;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign push_desc = desc_s2;

	always_comb begin
		hund_c = '0;
		for (int i = 1; i < 10; i++) begin
			if (in_value >= hundreds_of(DIGIT_W'(i))) begin
				hund_c = DIGIT_W'(i);
			end
		end
		rem_c = in_value - hundreds_of(hund_c);
	end

	always_comb begin
		tens_c = '0;
		for (int i = 1; i < 10; i++) begin
			if (rem_s1 >= tens_of(DIGIT_W'(i))) begin
				tens_c = DIGIT_W'(i);
			end
		end
		units_c = rem_s1 - tens_of(tens_c);
		priority if (err_s1) begin
			total_c = '0;
		end else if (thou_s1) begin
			total_c = POS_W'(1);
		end else begin
			total_c = POS_W'(digit_len(hund_s1)) + POS_W'(digit_len(tens_c))
				+ POS_W'(digit_len(units_c[DIGIT_W-1:0]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			err_s1  <= (in_value == '0) || (in_value > VALUE_MAX);
			thou_s1 <= (in_value == VALUE_MAX);
			hund_s1 <= hund_c;
			rem_s1  <= rem_c[REM_W-1:0];
		end
		if (adv2) begin
			desc_s2.err   <= err_s1;
			desc_s2.thou  <= thou_s1;
			desc_s2.hund  <= hund_s1;
			desc_s2.tens  <= tens_c;
			desc_s2.units <= units_c[DIGIT_W-1:0];
			desc_s2.total <= total_c;
		end
	end

endmodule

@@ rtl/rne_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_fifo
// Small descriptor queue between the classifier and the symbol sequencer.
// ----------------------------------------------------------------------------
module rne_fifo #(
	parameter int DEPTH = rne_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rne_pkg::desc_t push_desc,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output rne_pkg::desc_t head
);
	import rne_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> $stable(wr_ptr_q))
		else $error("write pointer moved while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |=> $stable(rd_ptr_q))
		else $error("read pointer moved while empty");
`endif

endmodule

@@ rtl/rne_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_back
// Symbol sequencer: walks the digits of the head descriptor, one symbol per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module rne_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           empty,
	input  rne_pkg::desc_t                 head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rne_pkg::SYMBOL_W-1:0]   out_symbol,
	output logic [rne_pkg::POS_W-1:0]      out_position,
	output logic [rne_pkg::POS_W-1:0]      out_total,
	output logic                           out_last,
	output logic                           out_error
);
	import rne_pkg::*;

	logic [1:0]          dsel_q;
	logic [1:0]          k_q;
	logic [POS_W-1:0]    pos_q;
	logic                out_valid_q;
	logic [SYMBOL_W-1:0] symbol_q;
	logic [POS_W-1:0]    position_q;
	logic [POS_W-1:0]    total_q;
	logic                last_q;
	logic                error_q;

	logic                out_en;
	logic                emit;
	logic                last_c;
	logic                done_c;
	logic [LEN_W-1:0]    len_c [3];
	scale_t              eff_c;
	logic [DIGIT_W-1:0]  dig_c;
	logic [SYMBOL_W-1:0] sym_c;

	assign out_en = !out_valid_q || out_ready;
	assign emit   = out_en && !empty;

	always_comb begin
		len_c[0] = digit_len(head.hund);
		len_c[1] = digit_len(head.tens);
		len_c[2] = digit_len(head.units);
		priority if (dsel_q == 2'd0 && len_c[0] != '0) begin
			eff_c = SCALE_HUNDREDS;
		end else if (dsel_q <= 2'd1 && len_c[1] != '0) begin
			eff_c = SCALE_TENS;
		end else begin
			eff_c = SCALE_UNITS;
		end
		unique case (eff_c)
			SCALE_HUNDREDS: dig_c = head.hund;
			SCALE_TENS:     dig_c = head.tens;
			default:        dig_c = head.units;
		endcase
		priority if (head.err) begin
			sym_c = SYM_ERR;
		end else if (head.thou) begin
			sym_c = SYM_M;
		end else begin
			sym_c = symbol_of(eff_c, digit_sel(dig_c, k_q));
		end
		last_c = (pos_q + POS_W'(1) == head.total);
		done_c = head.err || head.thou || last_c;
	end

	assign pop = emit && done_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsel_q      <= '0;
			k_q         <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_en) begin
				out_valid_q <= !empty;
			end
			if (emit) begin
				if (done_c) begin
					dsel_q <= '0;
					k_q    <= '0;
					pos_q  <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					if ({1'b0, k_q} + LEN_W'(1) < len_c[eff_c]) begin
						dsel_q <= eff_c;
						k_q    <= k_q + 2'd1;
					end else begin
						dsel_q <= eff_c + 2'd1;
						k_q    <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			symbol_q   <= sym_c;
			position_q <= head.err ? '0 : pos_q;
			total_q    <= head.total;
			last_q     <= done_c;
			error_q    <= head.err;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_symbol   = symbol_q;
	assign out_position = position_q;
	assign out_total    = total_q;
	assign out_last     = last_q;
	assign out_error    = error_q;

`ifndef SYNTHESIS
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_q |-> last_q && total_q == '0 && position_q == '0)
		else $error("error transfer is not a single last item");
	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !error_q |-> (last_q == (position_q + POS_W'(1) == total_q)))
		else $error("last mark does not match position and length");
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !error_q |-> position_q < total_q)
		else $error("position beyond numeral length");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(symbol_q) && $stable(position_q))
		else $error("output changed while stalled");
`endif

endmodule

@@ rtl/roman_numeral_encoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top
// Integer to Roman numeral encoder, one ASCII symbol per output transfer.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one number per transfer in tdata[9:0]; 1 to 1000 is valid
//   m_axis gives one symbol per transfer; tlast marks the final symbol, tuser
//   flags an out-of-range number, which yields one transfer with symbol 0,
//   position 0 and length 0
//   a number is classified in two stages, queued, then a sequencer emits its
//   symbols at one per cycle while m_axis is not stalled; a numeral is 1 to
//   12 symbols long; numbers are accepted at the rate the output drains
//   them, with a few held in the stages and queue meanwhile
//   a number passes stage 1, stage 2 and the queue to the output register
//   a stall on m_axis holds the output register; the queue and the front keep
//   taking numbers until they fill, then s_axis_tready drops
//   reset clears all valid state; no transfer is pending after reset
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top #(
	parameter int FIFO_DEPTH = rne_pkg::FIFO_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [rne_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // value[9:0], zero fill
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [rne_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // symbol[7:0], position[11:8], total_length[15:12]
	output logic                             m_axis_tlast,
	output logic                             m_axis_tuser   // error
);
	import rne_pkg::*;

	logic                push;
	logic                full;
	logic                pop;
	logic                empty;
	desc_t               push_desc;
	desc_t               head;
	logic [SYMBOL_W-1:0] symbol;
	logic [POS_W-1:0]    position;
	logic [POS_W-1:0]    total_length;
	logic                unused_pad;

	assign unused_pad = ^s_axis_tdata[IN_DATA_W-1:VALUE_W];

	rne_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata[VALUE_W-1:0]),
		.push      (push),
		.full      (full),
		.push_desc (push_desc)
	);

	rne_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	rne_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_symbol   (symbol),
		.out_position (position),
		.out_total    (total_length),
		.out_last     (m_axis_tlast),
		.out_error    (m_axis_tuser)
	);

	assign m_axis_tdata = {total_length, position, symbol};

endmodule
